@@ sv/lrip_pkg.sv @@
package lrip_pkg;

  localparam int ROWS_DEF       = 64;
  localparam int COLUMNS_DEF    = 900;
  localparam int COORD_BITS_DEF = 18;

  localparam int CORDIC_STEPS = 20;
  localparam int ANGLE_PI     = 1048576;
  localparam int TAN_SHIFT    = 24;

  localparam logic [17:0] RANGE_MAX    = 18'h3FFFF;
  localparam logic [16:0] OFFSET_RESET = 17'd30282;
  localparam logic [15:0] SCALE_RESET  = 16'd32967;
  localparam logic [63:0] TAN_LIMIT    = 64'd1 << 40;

  // Register index taken from the word address.
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_SCALE  = 1'b1;

  typedef enum logic [1:0] {
    OP_PROJECT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEARED = 2'd2
  } kind_t;

  typedef struct packed {
    logic       load_point;
    logic       load_read;
    logic       square;
    logic       sum;
    logic       sqrt_step;
    logic       take_range;
    logic       take_h;
    logic       div_step;
    logic       tan;
    logic       mul_lo;
    logic       mul_hi;
    logic       row_col;
    logic       addr_calc;
    logic       cordic_step;
    logic [4:0] cordic_idx;
    logic       clear_init;
    logic       clear_step;
    logic       ram_we;
    logic       ram_zero;
    logic       out_point;
    logic       out_read;
    logic       out_clear;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

  // Arctangent of 2^-i in binary angle units, pi = 2^20.
  function automatic logic [20:0] atan_entry(input logic [4:0] i);
    logic [20:0] v;
    case (i)
      5'd0:    v = 21'd262144;
      5'd1:    v = 21'd154753;
      5'd2:    v = 21'd81766;
      5'd3:    v = 21'd41506;
      5'd4:    v = 21'd20834;
      5'd5:    v = 21'd10427;
      5'd6:    v = 21'd5215;
      5'd7:    v = 21'd2608;
      5'd8:    v = 21'd1304;
      5'd9:    v = 21'd652;
      5'd10:   v = 21'd326;
      5'd11:   v = 21'd163;
      5'd12:   v = 21'd81;
      5'd13:   v = 21'd41;
      5'd14:   v = 21'd20;
      5'd15:   v = 21'd10;
      5'd16:   v = 21'd5;
      5'd17:   v = 21'd3;
      5'd18:   v = 21'd1;
      5'd19:   v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/lidar_range_image_projection.sv @@
// Channel   Handshake              Fields
// command   start, busy            opcode, x_mm, y_mm, z_mm, read_row, read_column
// result    done (one cycle)       kind, row, column, range_mm
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A projected point uses the shared bit-serial square root (run twice)
// and the restoring divider for the elevation tangent. A clear sweeps
// the image memory one entry per cycle.
// After reset the same sweep zeroes the memory while busy stays high;
// configuration writes are taken throughout.
// done is high for exactly one cycle per result and cannot be stalled.
module lidar_range_image_projection #(
  parameter int ROWS       = lrip_pkg::ROWS_DEF,
  parameter int COLUMNS    = lrip_pkg::COLUMNS_DEF,
  parameter int COORD_BITS = lrip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] x_mm,
  input  logic signed [COORD_BITS-1:0] y_mm,
  input  logic signed [COORD_BITS-1:0] z_mm,
  input  logic [5:0]                   read_row,
  input  logic [9:0]                   read_column,
  output logic                         done,
  output logic [1:0]                   kind,
  output logic [5:0]                   row,
  output logic [9:0]                   column,
  output logic [17:0]                  range_mm,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import lrip_pkg::*;

  logic [16:0] vertical_offset;
  logic [15:0] vertical_scale;
  cmd_t        cmd;
  status_t     status;

  // The register is chosen by the word address; byte offset bits are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_offset <= OFFSET_RESET;
      vertical_scale  <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_OFFSET: vertical_offset <= pwdata[16:0];
        REG_SCALE:  vertical_scale  <= pwdata[15:0];
        default:    vertical_offset <= vertical_offset;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OFFSET: prdata = {15'b0, vertical_offset};
      REG_SCALE:  prdata = {16'b0, vertical_scale};
      default:    prdata = '0;
    endcase
  end

  // The controller sequences the shared iterative units; the datapath holds
  // the point, the square root, divider, CORDIC and the image memory.
  lrip_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lrip_dpath #(
    .ROWS       (ROWS),
    .COLUMNS    (COLUMNS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .x_mm            (x_mm),
    .y_mm            (y_mm),
    .z_mm            (z_mm),
    .read_row        (read_row),
    .read_column     (read_column),
    .vertical_offset (vertical_offset),
    .vertical_scale  (vertical_scale),
    .kind            (kind),
    .row             (row),
    .column          (column),
    .range_mm        (range_mm)
  );

  // A result only follows work in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

  // Every real command makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != OP_NONE) |=> busy)
    else $error("accepted command did not start work");

  // No two results in consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // A finished clear reports an empty pixel.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_CLEARED) |-> (row == '0 && column == '0 && range_mm == '0))
    else $error("clear result carries data");

endmodule

@@ sv/lrip_ram.sv @@
module lrip_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 57600
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/lrip_dpath.sv @@
module lrip_dpath #(
  parameter int ROWS       = 64,
  parameter int COLUMNS    = 900,
  parameter int COORD_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lrip_pkg::cmd_t               cmd,
  output lrip_pkg::status_t            status,
  input  logic signed [COORD_BITS-1:0] x_mm,
  input  logic signed [COORD_BITS-1:0] y_mm,
  input  logic signed [COORD_BITS-1:0] z_mm,
  input  logic [5:0]                   read_row,
  input  logic [9:0]                   read_column,
  input  logic [16:0]                  vertical_offset,
  input  logic [15:0]                  vertical_scale,
  output logic [1:0]                   kind,
  output logic [5:0]                   row,
  output logic [9:0]                   column,
  output logic [17:0]                  range_mm
);

  import lrip_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int SW    = 2 * C + 18;
  localparam int HW    = SW / 2;
  localparam int MW    = C + TAN_SHIFT;
  localparam int CW    = C + 23;
  localparam int ANGW  = 23;
  localparam int TW    = 42;
  localparam int NUMW  = 38;
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int ADW   = $clog2(DEPTH);

  logic signed [C-1:0] xr, yr, zr;
  logic [C-1:0]        xa, ya, za, xin_a;
  logic [2*C-1:0]      xsq, ysq, zsq;
  logic [2*C:0]        hsq;
  logic                hz;

  logic [SW-1:0]   rad;
  logic [HW-1:0]   root;
  logic [HW+1:0]   srem;
  logic [HW+3:0]   s_sh, s_trial;
  logic [17:0]     range_q;

  logic [HW-1:0]   h8;
  logic [MW-1:0]   dvd;
  logic [HW:0]     drem, d_sh;

  logic [63:0]            q_ext;
  logic [40:0]            q_sat;
  logic signed [TW-1:0]   t_val;
  logic signed [TW:0]     a_q;
  logic [36:0]            pl;
  logic signed [38:0]     ph;
  logic signed [60:0]     psum;
  logic signed [37:0]     rdiff;
  logic signed [23:0]     adiff;
  logic signed [NUMW-1:0] num;
  logic [RW-1:0]          row_next;
  logic [CLW-1:0]         col_next;

  logic signed [CW-1:0]   cx, cy, dx, dy;
  logic signed [ANGW-1:0] ang, tstep;
  logic signed [C:0]      xs, ys;
  logic                   origin;

  logic [RW-1:0]  row_q;
  logic [CLW-1:0] col_q;
  logic [ADW-1:0] addr;
  logic [17:0]    rdata;

  assign xa    = xr[C-1] ? $unsigned(-xr) : $unsigned(xr);
  assign ya    = yr[C-1] ? $unsigned(-yr) : $unsigned(yr);
  assign za    = zr[C-1] ? $unsigned(-zr) : $unsigned(zr);
  assign xin_a = '0;

  // One bit pair of the square root per step.
  assign s_sh    = {srem, rad[SW-1:SW-2]};
  assign s_trial = {2'b00, root, 2'b01};

  // One quotient bit per step.
  assign d_sh = {drem[HW-1:0], dvd[MW-1]};

  // Input sign folding for the angle; the x<0 half turns by pi.
  assign xs = x_mm[C-1] ? -((C+1)'(x_mm)) : (C+1)'(x_mm);
  assign ys = x_mm[C-1] ? -((C+1)'(y_mm)) : (C+1)'(y_mm);

  assign dx    = cy >>> cmd.cordic_idx;
  assign dy    = cx >>> cmd.cordic_idx;
  assign tstep = $signed({2'b00, atan_entry(cmd.cordic_idx)});

  always_comb begin
    q_ext = 64'(dvd) + 64'(zr[C-1] && (drem != '0));
    q_sat = (q_ext > TAN_LIMIT) ? 41'(TAN_LIMIT) : q_ext[40:0];
    t_val = zr[C-1] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    adiff = $signed(24'(ANGLE_PI)) - 24'(ang);

    psum  = 61'($signed({ph, 21'b0})) + $signed({24'b0, pl});
    rdiff = $signed(38'(ROWS)) - 38'($signed(psum[60:24]));
    if (hz) begin
      row_next = zr[C-1] ? RW'(ROWS - 1) : '0;
    end else if (rdiff < 0) begin
      row_next = '0;
    end else if (rdiff > $signed(38'(ROWS - 1))) begin
      row_next = RW'(ROWS - 1);
    end else begin
      row_next = RW'(rdiff);
    end

    if (num < 0) begin
      col_next = '0;
    end else if (num[NUMW-1:21] > 17'(COLUMNS - 1)) begin
      col_next = CLW'(COLUMNS - 1);
    end else begin
      col_next = CLW'(num[NUMW-1:21]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      xr     <= x_mm;
      yr     <= y_mm;
      zr     <= z_mm;
      origin <= (x_mm == '0) && (y_mm == '0);
      cx     <= CW'(xs) <<< 20;
      cy     <= CW'(ys) <<< 20;
      if (x_mm[C-1]) begin
        ang <= y_mm[C-1] ? -$signed(ANGW'(ANGLE_PI)) : $signed(ANGW'(ANGLE_PI));
      end else begin
        ang <= '0;
      end
    end else if (cmd.cordic_step && !origin) begin
      if (!cy[CW-1]) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + tstep;
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - tstep;
      end
    end

    if (cmd.square) begin
      xsq <= xa * xa;
      ysq <= ya * ya;
      zsq <= za * za;
    end
    if (cmd.sum) begin
      hsq  <= {1'b0, xsq} + {1'b0, ysq} + (2*C+1)'(xin_a);
      rad  <= SW'({2'b00, xsq} + {2'b00, ysq} + {2'b00, zsq});
      root <= '0;
      srem <= '0;
    end else if (cmd.take_range) begin
      range_q <= (64'(root) > 64'(RANGE_MAX)) ? RANGE_MAX : 18'(root);
      hz      <= (hsq == '0);
      rad     <= SW'({hsq, 16'b0});
      root    <= '0;
      srem    <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[SW-3:0], 2'b00};
      if (s_sh >= s_trial) begin
        srem <= (HW+2)'(s_sh - s_trial);
        root <= {root[HW-2:0], 1'b1};
      end else begin
        srem <= (HW+2)'(s_sh);
        root <= {root[HW-2:0], 1'b0};
      end
    end

    if (cmd.take_h) begin
      h8   <= (root == '0) ? HW'(1) : root;
      dvd  <= {za, 24'b0};
      drem <= '0;
    end else if (cmd.div_step) begin
      if (d_sh >= {1'b0, h8}) begin
        drem <= d_sh - {1'b0, h8};
        dvd  <= {dvd[MW-2:0], 1'b1};
      end else begin
        drem <= d_sh;
        dvd  <= {dvd[MW-2:0], 1'b0};
      end
    end

    if (cmd.tan) begin
      a_q <= (TW+1)'(t_val) + $signed({26'b0, vertical_offset});
      num <= NUMW'(adiff * $signed(14'(COLUMNS)));
    end
    if (cmd.mul_lo) begin
      pl <= a_q[20:0] * vertical_scale;
    end
    if (cmd.mul_hi) begin
      ph <= $signed(a_q[TW:21]) * $signed({1'b0, vertical_scale});
    end

    if (cmd.row_col) begin
      row_q <= row_next;
      col_q <= col_next;
    end else if (cmd.load_read) begin
      row_q <= (32'(read_row) > 32'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(read_row);
      col_q <= (32'(read_column) > 32'(COLUMNS - 1)) ? CLW'(COLUMNS - 1) : CLW'(read_column);
    end

    if (cmd.out_point) begin
      kind     <= KIND_STORED;
      row      <= 6'(row_q);
      column   <= 10'(col_q);
      range_mm <= range_q;
    end else if (cmd.out_read) begin
      kind     <= KIND_READ;
      row      <= 6'(row_q);
      column   <= 10'(col_q);
      range_mm <= rdata & RANGE_MAX;
    end else if (cmd.out_clear) begin
      kind     <= KIND_CLEARED;
      row      <= '0;
      column   <= '0;
      range_mm <= '0;
    end
  end

  // The address register doubles as the clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.clear_init) begin
      addr <= '0;
    end else if (cmd.clear_step) begin
      addr <= addr + ADW'(1);
    end else if (cmd.addr_calc) begin
      addr <= ADW'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
    end
  end

  assign status.clear_last = (addr == ADW'(DEPTH - 1));

  lrip_ram #(
    .WIDTH (18),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (addr),
    .wdata (cmd.ram_zero ? 18'd0 : range_q),
    .rdata (rdata)
  );

endmodule

@@ sv/lrip_ctrl.sv @@
module lrip_ctrl #(
  parameter int COORD_BITS = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  lrip_pkg::status_t status,
  output lrip_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  import lrip_pkg::*;

  localparam int SQ_STEPS  = (2 * COORD_BITS + 18) / 2;
  localparam int DIV_STEPS = COORD_BITS + TAN_SHIFT;
  localparam int CNTW      = $clog2(DIV_STEPS + 1);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_CLEAR  = 17'h00002,
    S_SQUARE = 17'h00004,
    S_SUM    = 17'h00008,
    S_SQRT_R = 17'h00010,
    S_HLOAD  = 17'h00020,
    S_SQRT_H = 17'h00040,
    S_DLOAD  = 17'h00080,
    S_DIV    = 17'h00100,
    S_TAN    = 17'h00200,
    S_MUL_LO = 17'h00400,
    S_MUL_HI = 17'h00800,
    S_ROWCOL = 17'h01000,
    S_ADDR   = 17'h02000,
    S_WRITE  = 17'h04000,
    S_READ   = 17'h08000,
    S_RWAIT  = 17'h10000
  } state_t;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt;
  logic [4:0]      ccnt;
  logic            is_read, report;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.cordic_idx  = ccnt;
    cmd.cordic_step = (ccnt != 5'(CORDIC_STEPS)) &&
                      (state == S_SQRT_R || state == S_HLOAD || state == S_SQRT_H);
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_PROJECT: begin
              cmd.load_point = 1'b1;
              state_next     = S_SQUARE;
            end
            OP_READ: begin
              cmd.load_read = 1'b1;
              state_next    = S_ADDR;
            end
            OP_CLEAR: begin
              cmd.clear_init = 1'b1;
              state_next     = S_CLEAR;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.ram_we     = 1'b1;
        cmd.ram_zero   = 1'b1;
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          cmd.out_clear = report;
          state_next    = S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_SQRT_R;
      end
      S_SQRT_R: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CNTW'(SQ_STEPS - 1)) begin
          state_next = S_HLOAD;
        end
      end
      S_HLOAD: begin
        cmd.take_range = 1'b1;
        state_next     = S_SQRT_H;
      end
      S_SQRT_H: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CNTW'(SQ_STEPS - 1)) begin
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.take_h = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(DIV_STEPS - 1)) begin
          state_next = S_TAN;
        end
      end
      S_TAN: begin
        cmd.tan    = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ROWCOL;
      end
      S_ROWCOL: begin
        cmd.row_col = 1'b1;
        state_next  = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = is_read ? S_READ : S_WRITE;
      end
      S_WRITE: begin
        cmd.ram_we    = 1'b1;
        cmd.out_point = 1'b1;
        state_next    = S_IDLE;
      end
      S_READ: begin
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.out_read = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      ccnt    <= '0;
      is_read <= 1'b0;
      report  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CNTW'(1);
      if (cmd.load_point) begin
        ccnt <= '0;
      end else if (cmd.cordic_step) begin
        ccnt <= ccnt + 5'd1;
      end
      if (state == S_IDLE && start) begin
        is_read <= (opcode == OP_READ);
        report  <= (opcode == OP_CLEAR);
      end
      done <= cmd.out_point || cmd.out_read || cmd.out_clear;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
